### sv/assert_macros.svh
// Assertion macros shared by the divider modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an expression on every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

### sv/fdu_pkg.sv
// Types and operation codes of the floored divide and modulo unit.
`default_nettype none
package fdu_pkg;

	localparam int PORT_W = 64;

	localparam logic [2:0] OP_MOD_SS  = 3'd0;
	localparam logic [2:0] OP_MOD_US  = 3'd1;
	localparam logic [2:0] OP_MOD_SU  = 3'd2;
	localparam logic [2:0] OP_MOD_UU  = 3'd3;
	localparam logic [2:0] OP_FDIV_SS = 3'd4;

	typedef struct packed {
		logic [2:0]        req_type;
		logic [PORT_W-1:0] operand_a;
		logic [PORT_W-1:0] operand_b;
	} req_t;

	typedef struct packed {
		logic [PORT_W-1:0] result_bits;
		logic              div_by_zero;
	} rsp_t;

	// Control carried alongside each word through the cell chain.
	typedef struct packed {
		logic vld;
		logic is_div;
		logic a_neg;
		logic b_neg;
		logic zero;
		logic dz;
	} ctl_t;

endpackage
`default_nettype wire

### sv/fdu_prep.sv
// Operand decode: signs, magnitudes and the dividend fed to the cell chain.
`default_nettype none
module fdu_prep
	import fdu_pkg::*;
#(
	parameter int W = 64
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         vld,
	input  wire req_t         req,
	output ctl_t              ctl_s1,
	output logic [W-1:0]      dq_s1,
	output logic [W-1:0]      bm_s1
);

	localparam logic [W-1:0] ONE = W'(1);

	logic [W-1:0] a, b, bm, d;
	logic         a_sgn, b_sgn, op_ok, is_div, a_neg, b_neg, diff;

	// decode the operation into operand signedness
	always_comb begin
		a_sgn  = 1'b0;
		b_sgn  = 1'b0;
		op_ok  = 1'b1;
		is_div = 1'b0;
		unique case (req.req_type)
			OP_MOD_SS: begin
				a_sgn = 1'b1;
				b_sgn = 1'b1;
			end
			OP_MOD_US: b_sgn = 1'b1;
			OP_MOD_SU: a_sgn = 1'b1;
			OP_MOD_UU: ;
			OP_FDIV_SS: begin
				a_sgn  = 1'b1;
				b_sgn  = 1'b1;
				is_div = 1'b1;
			end
			default: op_ok = 1'b0;
		endcase
	end

	// take magnitudes; with opposite signs the dividend is |a| - 1
	always_comb begin
		a     = req.operand_a[W-1:0];
		b     = req.operand_b[W-1:0];
		a_neg = a_sgn & a[W-1];
		b_neg = b_sgn & b[W-1];
		diff  = a_neg ^ b_neg;
		bm    = b_neg ? (~b + ONE) : b;
		case ({a_neg, diff})
			2'b11:   d = ~a;
			2'b10:   d = ~a + ONE;
			2'b01:   d = a - ONE;
			default: d = a;
		endcase
	end

	// register the decoded word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.vld    <= vld;
			ctl_s1.is_div <= is_div;
			ctl_s1.a_neg  <= a_neg;
			ctl_s1.b_neg  <= b_neg;
			ctl_s1.zero   <= !op_ok || (a == '0) || (b == '0);
			ctl_s1.dz     <= op_ok && (b == '0);
		end
	end

	always_ff @(posedge clk) begin
		dq_s1 <= d;
		bm_s1 <= bm;
	end

endmodule
`default_nettype wire

### sv/fdu_cell.sv
// One restoring division step: one quotient bit per cell.
`default_nettype none
`include "assert_macros.svh"
module fdu_cell
	import fdu_pkg::*;
#(
	parameter int W = 64
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire ctl_t         ctl_i,
	input  wire logic [W-1:0] rem_i,
	input  wire logic [W-1:0] dq_i,
	input  wire logic [W-1:0] bm_i,
	output ctl_t              ctl_q,
	output logic [W-1:0]      rem_q,
	output logic [W-1:0]      dq_q,
	output logic [W-1:0]      bm_q
);

	logic [W:0]   shifted, trial;
	logic         ge;
	logic [W-1:0] rem_nx;

	// shift in the next dividend bit and try to subtract the divisor
	always_comb begin
		shifted = {rem_i, dq_i[W-1]};
		trial   = shifted - {1'b0, bm_i};
		ge      = !trial[W];
		rem_nx  = ge ? trial[W-1:0] : shifted[W-1:0];
	end

	// hand the word on to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		rem_q <= rem_nx;
		dq_q  <= {dq_i[W-2:0], ge};
		bm_q  <= bm_i;
	end

	`ASSERT_IMPLY(a_rem_below_divisor, ctl_q.vld && !ctl_q.zero, rem_q < bm_q, "partial remainder not below divisor")

endmodule
`default_nettype wire

### sv/fdu_post.sv
// Result fix-up: floor correction, sign and special cases.
`default_nettype none
`include "assert_macros.svh"
module fdu_post
	import fdu_pkg::*;
#(
	parameter int W = 64
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire ctl_t         ctl_i,
	input  wire logic [W-1:0] rem_i,
	input  wire logic [W-1:0] quot_i,
	input  wire logic [W-1:0] bm_i,
	output rsp_t              result_q,
	output logic              done_q
);

	localparam logic [W-1:0] ONE = W'(1);

	logic              diff;
	logic [W-1:0]      res;
	logic [PORT_W-1:0] res_full;

	// apply floor rounding and the divisor's sign, or give zero for the special cases
	always_comb begin
		diff = ctl_i.a_neg ^ ctl_i.b_neg;
		if (ctl_i.zero) begin
			res = '0;
		end else if (ctl_i.is_div) begin
			res = diff ? ~quot_i : quot_i;
		end else begin
			case ({diff, ctl_i.b_neg})
				2'b00:   res = rem_i;
				2'b01:   res = ~rem_i + ONE;
				2'b10:   res = bm_i + ~rem_i;
				default: res = rem_i - bm_i + ONE;
			endcase
		end
		res_full         = '0;
		res_full[W-1:0]  = res;
	end

	// drive the result strobe for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl_i.vld;
		end
	end

	always_ff @(posedge clk) begin
		result_q.result_bits <= res_full;
		result_q.div_by_zero <= ctl_i.dz;
	end

	`ASSERT_IMPLY(a_dz_gives_zero, done_q && result_q.div_by_zero, result_q.result_bits == '0, "zero divisor with nonzero result")

endmodule
`default_nettype wire

### sv/floor_divmod_unit.sv
// Top level of the floored divide and modulo unit.
//
// Usage: raise start with a request word on req; the word is taken at any
// rising edge where start is high and busy is low. busy is never raised, so
// one word can be taken every cycle. req_type picks floored modulo for the four
// signed/unsigned pairings or signed floored division.
// Each result word appears on result for exactly one cycle, marked by done,
// in request order, after passing through one decode stage, a chain of
// DATA_WIDTH division cells, each resolving one quotient bit, and one
// fix-up stage. Throughput is one word per cycle.
// A zero divisor returns 0 with div_by_zero set; a zero dividend returns 0.
// Result bits above DATA_WIDTH are zero; operand bits above it are ignored.
// Reset clears every valid flag in the chain, so words in flight are dropped
// and no done strobe follows. The receiver cannot stall; it must take each
// word in the cycle it is shown.
`default_nettype none
`include "assert_macros.svh"
module floor_divmod_unit
	import fdu_pkg::*;
#(
	parameter int DATA_WIDTH = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	input  wire req_t req,
	output rsp_t      result,
	output logic      done
);

	localparam int W = DATA_WIDTH;

	ctl_t         ctl_c [0:W];
	logic [W-1:0] rem_c [0:W];
	logic [W-1:0] dq_c  [0:W];
	logic [W-1:0] bm_c  [0:W];

	// always ready: the chain takes a word every cycle
	assign busy     = 1'b0;
	assign rem_c[0] = '0;

	fdu_prep #(.W(W)) u_prep (
		.clk    (clk),
		.arst_n (arst_n),
		.vld    (start && !busy),
		.req    (req),
		.ctl_s1 (ctl_c[0]),
		.dq_s1  (dq_c[0]),
		.bm_s1  (bm_c[0])
	);

	// one cell per quotient bit
	for (genvar i = 0; i < W; i++) begin : g_cell
		fdu_cell #(.W(W)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl_i  (ctl_c[i]),
			.rem_i  (rem_c[i]),
			.dq_i   (dq_c[i]),
			.bm_i   (bm_c[i]),
			.ctl_q  (ctl_c[i+1]),
			.rem_q  (rem_c[i+1]),
			.dq_q   (dq_c[i+1]),
			.bm_q   (bm_c[i+1])
		);
	end

	fdu_post #(.W(W)) u_post (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_i    (ctl_c[W]),
		.rem_i    (rem_c[W]),
		.quot_i   (dq_c[W]),
		.bm_i     (bm_c[W]),
		.result_q (result),
		.done_q   (done)
	);

	`ASSERT_IMPLY(a_result_in_width, done, (result.result_bits >> DATA_WIDTH) == '0, "result bits set above data width")

endmodule
`default_nettype wire
